// ===== hw/rtl/byte_pair_expander_unit_defines.svh =====
// assertion macros for the byte pair expander
// used by the top level; needs nothing else
`ifndef BYTE_PAIR_EXPANDER_UNIT_DEFINES_SVH
`define BYTE_PAIR_EXPANDER_UNIT_DEFINES_SVH

// same-cycle implication
`define BPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bpe_pkg.sv =====
// shared types and constants of the byte pair expander
// no dependencies
`timescale 1ns / 1ps
package bpe_pkg;
   localparam int STACK_DEPTH = 256;
   localparam int SADDR_W     = $clog2(STACK_DEPTH);
   localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
   localparam int TBL_DEPTH   = 256;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_TABLE   = 2'd1;
   localparam logic [1:0] ERR_STACK   = 2'd2;
   localparam logic [1:0] ERR_ORDER   = 2'd3;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [2:0] {
      PH_COUNT      = 3'd0,
      PH_PAIR_LEFT  = 3'd1,
      PH_PAIR_RIGHT = 3'd2,
      PH_COUNT_NEXT = 3'd3,
      PH_LEN_HI     = 3'd4,
      PH_LEN_LO     = 3'd5,
      PH_DATA       = 3'd6
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        need_byte;
      logic        done_res;
      logic [1:0]  error_code;
      logic [31:0] bytes_out;
   } rsp_type;
endpackage

// ===== hw/rtl/byte_pair_expander_unit.sv =====
// Byte pair expander: one beat in, one beat out; no new beat is taken while one is in process.
// The cycle of acceptance presents the pair table and stack read addresses; the
// next cycle uses the registered read data, writes back and loads the result
// register or the spare, so the registered read of the pair table memory sets the rate.
// The pair table is one memory holding left and right codes side by side; the
// left byte is held until its right byte arrives and both are written together.
// A spare register behind the result register lets a new item in while a result
// still waits; the input stalls while an item is in process or the spare is occupied.
// Depends on bpe_pkg, bpe_ram and byte_pair_expander_unit_defines.svh.
`timescale 1ns / 1ps
`include "byte_pair_expander_unit_defines.svh"
module byte_pair_expander_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpe_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   logic [31:0] total_ff;
   logic        busy_ff;
   logic        op_ff, op_in;
   logic [7:0]  byte_ff;
   logic [7:0]  code_ff, code_in;
   bpe_pkg::phase_type phase_ff, phase_in;
   logic [bpe_pkg::LVL_W-1:0] level_ff, level_in;
   logic [7:0]  tos_ff, tos_in;
   logic [7:0]  lhold_ff, lhold_in;
   logic [8:0]  tidx_ff, tidx_in;
   logic [7:0]  pairs_ff, pairs_in;
   logic [15:0] blk_ff, blk_in;
   logic [31:0] prod_ff, prod_in;
   logic [1:0]  err_ff, err_in;
   logic [bpe_pkg::TBL_DEPTH-1:0] def_ff, def_in;
   logic        rsp_valid_ff;
   bpe_pkg::rsp_type rsp_ff, rsp_in;
   logic        spare_valid_ff;
   bpe_pkg::rsp_type spare_ff;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        accept;
   logic        pair_we, stk_we;
   logic [15:0] pair_rd;
   logic [7:0]  left_rd, right_rd, stk_rd;
   logic [bpe_pkg::SADDR_W-1:0] stk_waddr, stk_raddr;
   logic        done_now;
   logic [9:0]  cnt_sum;
   logic [7:0]  cnt_pairs;
   logic [8:0]  tidx_inc;
   logic [bpe_pkg::LVL_W-1:0] lvl_pop;
   logic [bpe_pkg::LVL_W:0]   lvl_chk;
   logic        done_next, need_next;

   function automatic logic [bpe_pkg::SADDR_W-1:0] bpe_sat_addr(
      input logic [bpe_pkg::LVL_W-1:0] lvl);
      logic [bpe_pkg::LVL_W-1:0] d;
      d = lvl - bpe_pkg::LVL_W'(2);
      return d[bpe_pkg::SADDR_W-1:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff || spare_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // code for the item being accepted: cached top of stack when popping a non-empty stack
   assign code_in   = (req_data.op == bpe_pkg::OP_POP && level_ff != '0) ? tos_ff
                                                                         : req_data.in_byte;
   assign stk_raddr = bpe_sat_addr(level_ff);
   assign op_in     = req_data.op;

   assign done_now = (prod_ff != '0) && (prod_ff >= total_ff);

   assign left_rd  = pair_rd[15:8];
   assign right_rd = pair_rd[7:0];

   bpe_ram #(.WIDTH(16), .DEPTH(bpe_pkg::TBL_DEPTH)) u_pair (
      .clock(clock), .wr_en(pair_we), .wr_addr(tidx_ff[7:0]),
      .wr_data({lhold_ff, byte_ff}), .rd_addr(code_in), .rd_data(pair_rd));
   bpe_ram #(.WIDTH(8), .DEPTH(bpe_pkg::STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(right_rd),
      .rd_addr(stk_raddr), .rd_data(stk_rd));

   // state update during the busy cycle
   always_comb begin
      phase_in  = phase_ff;
      level_in  = level_ff;
      tos_in    = tos_ff;
      lhold_in  = lhold_ff;
      tidx_in   = tidx_ff;
      pairs_in  = pairs_ff;
      blk_in    = blk_ff;
      prod_in   = prod_ff;
      err_in    = err_ff;
      def_in    = def_ff;
      emit      = 1'b0;
      emit_byte = '0;
      pair_we   = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      cnt_sum   = '0;
      cnt_pairs = '0;
      tidx_inc  = tidx_ff + 9'd1;
      lvl_pop   = level_ff;
      lvl_chk   = '0;
      if (busy_ff && err_ff == bpe_pkg::ERR_NONE && !done_now) begin
         if (op_ff == bpe_pkg::OP_POP &&
             !(phase_ff == bpe_pkg::PH_DATA && level_ff != '0)) begin
            err_in = bpe_pkg::ERR_ORDER;
         end else if (op_ff == bpe_pkg::OP_BYTE && phase_ff == bpe_pkg::PH_DATA &&
                      level_ff != '0) begin
            err_in = bpe_pkg::ERR_ORDER;
         end else begin
            case (phase_ff)
               bpe_pkg::PH_COUNT, bpe_pkg::PH_COUNT_NEXT: begin
                  if (phase_ff == bpe_pkg::PH_COUNT) begin
                     def_in  = '0;
                     cnt_sum = 10'd0;
                  end else begin
                     cnt_sum = {1'b0, tidx_ff};
                  end
                  cnt_pairs = byte_ff;
                  // counts above 127 skip literal codes
                  if (byte_ff > 8'd127) begin
                     cnt_sum   = cnt_sum + 10'(byte_ff - 8'd127);
                     cnt_pairs = '0;
                  end
                  tidx_in = cnt_sum[8:0];
                  if (cnt_sum == 10'd256) begin
                     phase_in = bpe_pkg::PH_LEN_HI;
                  end else if (cnt_sum > 10'd256) begin
                     err_in = bpe_pkg::ERR_TABLE;
                  end else begin
                     pairs_in = cnt_pairs;
                     phase_in = bpe_pkg::PH_PAIR_LEFT;
                  end
               end
               bpe_pkg::PH_PAIR_LEFT, bpe_pkg::PH_PAIR_RIGHT: begin
                  if (phase_ff == bpe_pkg::PH_PAIR_LEFT) begin
                     // left byte waits for its right byte; literal entries are never read
                     lhold_in             = byte_ff;
                     def_in[tidx_ff[7:0]] = (byte_ff != tidx_ff[7:0]);
                  end else begin
                     pair_we = 1'b1;
                  end
                  if (phase_ff == bpe_pkg::PH_PAIR_LEFT && byte_ff != tidx_ff[7:0]) begin
                     phase_in = bpe_pkg::PH_PAIR_RIGHT;
                  end else begin
                     tidx_in = tidx_inc;
                     if (pairs_ff == '0) begin
                        phase_in = tidx_inc[8] ? bpe_pkg::PH_LEN_HI
                                               : bpe_pkg::PH_COUNT_NEXT;
                     end else begin
                        pairs_in = pairs_ff - 8'd1;
                        if (tidx_inc[8]) begin
                           err_in = bpe_pkg::ERR_TABLE;
                        end else begin
                           phase_in = bpe_pkg::PH_PAIR_LEFT;
                        end
                     end
                  end
               end
               bpe_pkg::PH_LEN_HI: begin
                  blk_in   = {byte_ff, 8'd0};
                  phase_in = bpe_pkg::PH_LEN_LO;
               end
               bpe_pkg::PH_LEN_LO: begin
                  blk_in   = {blk_ff[15:8], byte_ff};
                  phase_in = ({blk_ff[15:8], byte_ff} != '0) ? bpe_pkg::PH_DATA
                                                             : bpe_pkg::PH_COUNT;
               end
               bpe_pkg::PH_DATA: begin
                  if (level_ff == '0) begin
                     if (blk_ff != '0) begin
                        blk_in = blk_ff - 16'd1;
                     end
                  end else begin
                     lvl_pop = level_ff - bpe_pkg::LVL_W'(1);
                     tos_in  = stk_rd;
                  end
                  level_in = lvl_pop;
                  lvl_chk  = {1'b0, lvl_pop} + (bpe_pkg::LVL_W+1)'(2);
                  if (def_ff[code_ff]) begin
                     if (lvl_chk >= (bpe_pkg::LVL_W+1)'(bpe_pkg::STACK_DEPTH)) begin
                        err_in = bpe_pkg::ERR_STACK;
                     end else begin
                        // right goes to memory, left stays cached as top
                        stk_we    = 1'b1;
                        stk_waddr = lvl_pop[bpe_pkg::SADDR_W-1:0];
                        tos_in    = left_rd;
                        level_in  = lvl_chk[bpe_pkg::LVL_W-1:0];
                     end
                  end else begin
                     emit      = 1'b1;
                     emit_byte = code_ff;
                     prod_in   = prod_ff + 32'd1;
                  end
                  if (err_in == bpe_pkg::ERR_NONE && level_in == '0 && blk_in == '0) begin
                     phase_in = bpe_pkg::PH_COUNT;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // result beat
   always_comb begin
      done_next = (prod_in != '0) && (prod_in >= total_ff);
      need_next = (err_in == bpe_pkg::ERR_NONE) && !done_next &&
                  !(phase_in == bpe_pkg::PH_DATA && level_in != '0);
      rsp_in.out_valid  = emit;
      rsp_in.out_byte   = emit_byte;
      rsp_in.need_byte  = need_next;
      rsp_in.done_res   = done_next;
      rsp_in.error_code = err_in;
      rsp_in.bytes_out  = prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= 32'hFFFF_FFFF;
         busy_ff        <= 1'b0;
         phase_ff       <= bpe_pkg::PH_COUNT;
         level_ff       <= '0;
         tidx_ff        <= '0;
         pairs_ff       <= '0;
         blk_ff         <= '0;
         prod_ff        <= '0;
         err_ff         <= bpe_pkg::ERR_NONE;
         def_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         busy_ff  <= accept;
         phase_ff <= phase_in;
         level_ff <= level_in;
         tidx_ff  <= tidx_in;
         pairs_ff <= pairs_in;
         blk_ff   <= blk_in;
         prod_ff  <= prod_in;
         err_ff   <= err_in;
         def_ff   <= def_in;
         // output slot free or leaving: refill from the spare first
         if (!rsp_valid_ff || !rsp_stall) begin
            if (spare_valid_ff) begin
               rsp_valid_ff   <= 1'b1;
               spare_valid_ff <= busy_ff;
            end else begin
               rsp_valid_ff <= busy_ff;
            end
         end else if (busy_ff) begin
            spare_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff   <= tos_in;
      lhold_ff <= lhold_in;
      if (accept) begin
         op_ff   <= op_in;
         byte_ff <= req_data.in_byte;
         code_ff <= code_in;
      end
      if (!rsp_valid_ff || !rsp_stall) begin
         if (spare_valid_ff) begin
            rsp_ff <= spare_ff;
            if (busy_ff) begin
               spare_ff <= rsp_in;
            end
         end else if (busy_ff) begin
            rsp_ff <= rsp_in;
         end
      end else if (busy_ff) begin
         spare_ff <= rsp_in;
      end
   end

   `BPE_ASSERT_NEXT(a_busy_one_cycle, clock, reset, busy_ff, !busy_ff,
                    "item held busy for two cycles")
   `BPE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, busy_ff,
                    "accepted beat not processed")
   `BPE_ASSERT_NOW(a_level_bound, clock, reset, 1'b1,
                   level_ff < bpe_pkg::LVL_W'(bpe_pkg::STACK_DEPTH),
                   "stack level out of range")
   `BPE_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff != bpe_pkg::ERR_NONE,
                    err_ff == $past(err_ff), "error code changed after being set")
   `BPE_ASSERT_NEXT(a_result_loaded, clock, reset, busy_ff, rsp_valid_ff,
                    "result beat missing")
   `BPE_ASSERT_NOW(a_spare_behind_head, clock, reset, spare_valid_ff, rsp_valid_ff,
                   "spare result held with no result in front")
endmodule

// ===== hw/rtl/bpe_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== bench/tb_byte_pair_expander_unit.sv =====
// testbench for byte_pair_expander_unit: drives framed pair-table blocks and noise,
// predicts every result beat and checks it field by field
// depends on bpe_pkg and the byte_pair_expander_unit rtl
`timescale 1ns / 1ps

class expansion_scoreboard;
   logic [31:0] total_size;
   logic [7:0]  left_code [256];
   logic [7:0]  right_code [256];
   bit          pair_defined [256];
   logic [7:0]  expand_stack [bpe_pkg::STACK_DEPTH];
   int unsigned stack_level;
   bpe_pkg::phase_type phase;
   int unsigned table_index;
   int unsigned pairs_left;
   int unsigned block_remaining;
   logic [31:0] produced;
   logic [1:0]  error_state;
   bpe_pkg::rsp_type pending_rsp[$];
   int          mismatches;

   function new();
      total_size = 32'hFFFF_FFFF;
      stack_level = 0;
      phase = bpe_pkg::PH_COUNT;
      table_index = 0;
      pairs_left = 0;
      block_remaining = 0;
      produced = 0;
      error_state = bpe_pkg::ERR_NONE;
      mismatches = 0;
      foreach (pair_defined[i]) begin
         pair_defined[i] = 0;
         left_code[i] = 0;
         right_code[i] = 0;
      end
      foreach (expand_stack[i]) expand_stack[i] = 0;
   endfunction

   function bit finished();
      return produced != 0 && produced >= total_size;
   endfunction

   function bit stack_busy();
      return phase == bpe_pkg::PH_DATA && stack_level > 0;
   endfunction

   function void take_count(int unsigned cnt);
      int unsigned c;
      c = table_index;
      if (cnt > 127) begin
         c += cnt - 127;
         cnt = 0;
      end
      table_index = c & 9'h1FF;
      if (c == 256) phase = bpe_pkg::PH_LEN_HI;
      else if (c > 256) error_state = bpe_pkg::ERR_TABLE;
      else begin
         pairs_left = cnt;
         phase = bpe_pkg::PH_PAIR_LEFT;
      end
   endfunction

   function void next_entry();
      table_index = (table_index + 1) & 9'h1FF;
      if (pairs_left == 0) begin
         phase = (table_index >= 256) ? bpe_pkg::PH_LEN_HI : bpe_pkg::PH_COUNT_NEXT;
      end else begin
         pairs_left--;
         if (table_index >= 256) error_state = bpe_pkg::ERR_TABLE;
         else phase = bpe_pkg::PH_PAIR_LEFT;
      end
   endfunction

   function void emit_code(logic [7:0] c, ref bpe_pkg::rsp_type r);
      if (pair_defined[c]) begin
         if (stack_level + 2 >= bpe_pkg::STACK_DEPTH) begin
            error_state = bpe_pkg::ERR_STACK;
            return;
         end
         expand_stack[stack_level++] = right_code[c];
         expand_stack[stack_level++] = left_code[c];
      end else begin
         r.out_valid = 1;
         r.out_byte = c;
         produced++;
      end
   endfunction

   // advance the predicted state by one accepted input beat
   function void note_request(bpe_pkg::req_type q);
      bpe_pkg::rsp_type r;
      logic [7:0] b;
      int unsigned ti;
      b = q.in_byte;
      r = '0;
      if (error_state == bpe_pkg::ERR_NONE && !finished()) begin
         if (q.op == bpe_pkg::OP_POP && !stack_busy()) error_state = bpe_pkg::ERR_ORDER;
         else if (q.op == bpe_pkg::OP_BYTE && stack_busy()) error_state = bpe_pkg::ERR_ORDER;
         else begin
            ti = table_index & 8'hFF;
            case (phase)
               bpe_pkg::PH_COUNT: begin
                  foreach (pair_defined[i]) pair_defined[i] = 0;
                  table_index = 0;
                  take_count(b);
               end
               bpe_pkg::PH_PAIR_LEFT: begin
                  left_code[ti] = b;
                  pair_defined[ti] = (b != ti);
                  if (b != ti) phase = bpe_pkg::PH_PAIR_RIGHT;
                  else next_entry();
               end
               bpe_pkg::PH_PAIR_RIGHT: begin
                  right_code[ti] = b;
                  next_entry();
               end
               bpe_pkg::PH_COUNT_NEXT: take_count(b);
               bpe_pkg::PH_LEN_HI: begin
                  block_remaining = b << 8;
                  phase = bpe_pkg::PH_LEN_LO;
               end
               bpe_pkg::PH_LEN_LO: begin
                  block_remaining = (block_remaining | b) & 16'hFFFF;
                  phase = block_remaining != 0 ? bpe_pkg::PH_DATA : bpe_pkg::PH_COUNT;
               end
               bpe_pkg::PH_DATA: begin
                  if (stack_level == 0) begin
                     if (block_remaining != 0) block_remaining--;
                     emit_code(b, r);
                  end else begin
                     stack_level--;
                     emit_code(expand_stack[stack_level], r);
                  end
                  if (error_state == bpe_pkg::ERR_NONE && stack_level == 0 &&
                      block_remaining == 0) phase = bpe_pkg::PH_COUNT;
               end
               default: ;
            endcase
         end
      end
      r.done_res = finished();
      r.need_byte = error_state == bpe_pkg::ERR_NONE && !finished() && !stack_busy();
      r.error_code = error_state;
      r.bytes_out = produced;
      pending_rsp.push_back(r);
   endfunction

   function void check_response(bpe_pkg::rsp_type got);
      bpe_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h", got);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
          got.need_byte !== want.need_byte || got.done_res !== want.done_res ||
          got.error_code !== want.error_code || got.bytes_out !== want.bytes_out) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"result mismatch: expected v=%0d b=%h n=%0d d=%0d e=%0d c=%0d,",
                      " got v=%0d b=%h n=%0d d=%0d e=%0d c=%0d"},
               want.out_valid, want.out_byte, want.need_byte, want.done_res,
               want.error_code, want.bytes_out, got.out_valid, got.out_byte,
               got.need_byte, got.done_res, got.error_code, got.bytes_out);
      end
   endfunction
endclass

module tb_byte_pair_expander_unit;
   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   bpe_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   bpe_pkg::rsp_type rsp_data;
   logic    csr_wr_en = 0;
   logic [31:0] csr_wr_data = '0;

   expansion_scoreboard board;
   bit   quiet_tail = 0;
   bit   gaps_on = 1;
   bit   start_hold = 0;
   bit   long_hold = 0;
   int   hold_off = 0;
   int   items_sent = 0;

   byte_pair_expander_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver side: random stall bursts, and the long hold-off when it runs
   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1;
      end else if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else if (!quiet_tail && gaps_on && $urandom_range(0, 15) == 0) begin
         rsp_stall <= 1;
         hold_off <= $urandom_range(0, 17);
      end else rsp_stall <= 0;
   end

   // long receiver hold-off, counted here while the sender keeps going
   initial begin
      wait (start_hold);
      @(negedge clock);
      long_hold <= 1;
      repeat (300) @(negedge clock);
      long_hold <= 0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);

   // one beat with an optional idle burst ahead of it
   task automatic send_beat(logic op, logic [7:0] b);
      if (!quiet_tail && gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{op: op, in_byte: b};
      do @(posedge clock); while (req_stall);
      board.note_request('{op: op, in_byte: b});
      items_sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_total(logic [31:0] v);
      go_idle();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      board.total_size = v;
   endtask

   // pop until the stack is empty, as a well-behaved source would
   task automatic drain_stack();
      while (board.stack_busy() && board.error_state == bpe_pkg::ERR_NONE &&
             !board.finished())
         send_beat(bpe_pkg::OP_POP, 8'($urandom));
   endtask

   // a well-formed block: a few pairs in run-length form, then packed codes
   task automatic send_block(int n_codes, int n_pairs);
      int idx;
      int cnt;
      logic [7:0] lb;
      idx = 0;
      while (idx < 256) begin
         if ($urandom_range(0, 1) == 1 && n_pairs > 0) begin
            cnt = $urandom_range(0, n_pairs > 3 ? 3 : n_pairs - 1);
            if (idx + cnt + 1 > 256) cnt = 255 - idx;
            send_beat(bpe_pkg::OP_BYTE, 8'(cnt));
            for (int k = 0; k <= cnt; k++) begin
               // pairs only point to lower codes, so expansion terminates
               lb = (idx == 0 || $urandom_range(0, 4) == 0) ? 8'(idx)
                                                            : 8'($urandom_range(0, idx - 1));
               send_beat(bpe_pkg::OP_BYTE, lb);
               if (lb != 8'(idx))
                  send_beat(bpe_pkg::OP_BYTE, 8'($urandom_range(0, idx - 1)));
               idx++;
            end
            n_pairs -= cnt + 1;
         end else begin
            cnt = $urandom_range(1, 128);
            if (idx + cnt > 256) cnt = 256 - idx;
            send_beat(bpe_pkg::OP_BYTE, 8'(cnt + 127));
            idx += cnt;
            // a skip is followed by one entry unless it closes the table
            if (idx < 256) begin
               send_beat(bpe_pkg::OP_BYTE, 8'(idx));
               idx++;
            end
         end
      end
      send_beat(bpe_pkg::OP_BYTE, 8'(n_codes >> 8));
      send_beat(bpe_pkg::OP_BYTE, 8'(n_codes & 255));
      for (int k = 0; k < n_codes; k++) begin
         send_beat(bpe_pkg::OP_BYTE, 8'($urandom));
         drain_stack();
      end
   endtask

   initial begin
      board = new();
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: all-literal table, empty block, one-code block, max skip, zero total
      write_total(32'd0);
      send_beat(bpe_pkg::OP_BYTE, 8'd255);
      send_beat(bpe_pkg::OP_BYTE, 8'd128);
      send_beat(bpe_pkg::OP_BYTE, 8'd254);
      send_beat(bpe_pkg::OP_BYTE, 8'd0);
      send_beat(bpe_pkg::OP_BYTE, 8'd0);
      send_beat(bpe_pkg::OP_BYTE, 8'd255);
      send_beat(bpe_pkg::OP_BYTE, 8'd128);
      send_beat(bpe_pkg::OP_BYTE, 8'd254);
      send_beat(bpe_pkg::OP_BYTE, 8'd0);
      send_beat(bpe_pkg::OP_BYTE, 8'd1);
      send_beat(bpe_pkg::OP_BYTE, 8'h00);
      send_beat(bpe_pkg::OP_BYTE, 8'hFF);
      send_beat(bpe_pkg::OP_POP, 8'h00);
      go_idle();

      // long run with a large total; includes the receiver hold-off
      write_total(32'hFFFF_FFFF);
      start_hold = 1;
      while (items_sent < 1700 && board.error_state == bpe_pkg::ERR_NONE) begin
         if ($urandom_range(0, 9) == 0) send_block(0, 40);
         else send_block($urandom_range(1, 12), $urandom_range(1, 60));
      end

      // noise: wrong ops and table overruns end up sticky
      write_total(32'd2000);
      repeat (40) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      gaps_on = 0;
      repeat (20) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      gaps_on = 1;
      quiet_tail = 1;
      repeat (20) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      write_total(32'd1);
      send_beat(bpe_pkg::OP_POP, 8'hA5);
      req_valid <= 0;

      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (board.mismatches == 0) $display("byte_pair_expander_unit: match");
      else $display("byte_pair_expander_unit: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("byte_pair_expander_unit: mismatch");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bpe_pkg.sv
hw/rtl/bpe_ram.sv
hw/rtl/byte_pair_expander_unit.sv
bench/tb_byte_pair_expander_unit.sv
